// File: src/bfs_pkg.sv
// Types, register map and slot tables shared by the bitplane fetch sequencer.
// No dependencies; every other file in src imports this package.
package bfs_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_ENHANCED    = 2'd0,
        REG_SCROLL_ODD  = 2'd1,
        REG_SCROLL_EVEN = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] hpos;
        logic       con_write;
        logic [3:0] con_value;
        logic       enable_set;
        logic       enable_clear;
        logic       vert_set;
        logic       vert_clear;
        logic       start_hw;
        logic       stop_hw;
        logic       fetch_start;
        logic       fetch_stop;
        logic       end_line;
    } in_item_t;

    typedef struct packed {
        logic [2:0] fetch_plane;
        logic       fetch_hires;
        logic       fetch_modulo;
        logic       draw_odd;
        logic       draw_even;
        logic       line_end;
        logic       line_shown;
    } out_item_t;

    typedef struct packed {
        logic       enhanced_rules;
        logic [2:0] scroll_odd;
        logic [2:0] scroll_even;
    } cfg_t;

    typedef struct packed {
        logic       vert_window;
        logic       dma_enable;
        logic       hw_started;
        logic       hw_stopped;
        logic       fetch_started;
        logic       fetch_stopped;
        logic       running;
        logic       last_unit;
        logic [3:0] control_nibble;
        logic [2:0] slot_counter;
        logic       shown_flag;
    } seq_state_t;

    // plane per slot, 0 = idle slot
    localparam logic [2:0] LORES_SLOT [8] = '{3'd0, 3'd4, 3'd6, 3'd2, 3'd0, 3'd3, 3'd5, 3'd1};
    localparam logic [2:0] HIRES_SLOT [4] = '{3'd4, 3'd2, 3'd3, 3'd1};

    localparam logic [2:0] HIRES_MAX_PLANES = 3'd4;
    localparam logic [2:0] LORES_BAD_COUNT  = 3'd7;

    function automatic logic [2:0] slot_plane(input logic [3:0] nibble,
                                              input logic [2:0] slot);
        logic [2:0] count;
        logic [2:0] p;
        count = nibble[2:0];
        p     = 3'd0;
        if (nibble[3])
        begin
            if (count <= HIRES_MAX_PLANES)
            begin
                p = HIRES_SLOT[slot[1:0]];
            end
        end
        else
        begin
            // seven lores planes fetch as four
            if (count == LORES_BAD_COUNT)
            begin
                count = HIRES_MAX_PLANES;
            end
            p = LORES_SLOT[slot];
        end
        return ((p != 3'd0) && (p <= count)) ? p : 3'd0;
    endfunction

endpackage

// File: src/bitplane_fetch_sequencer.sv
// Bitplane fetch sequencer top level: input register, signal/fetch step, result register.
// Depends on bfs_pkg, bfs_cfg, bfs_signals and bfs_fetch.
//
// Path: an accepted item sits in the input register, then moves to the
// result register; the state update happens as the item moves into the result register.
// Throughput: one item per cycle while the output is not stalled; the state loop through the
// signal and fetch logic sets this. Stall from the output backs up one stage at a time.
// Reset: rst_n clears all sequencer state, the configuration registers and
// both valid flags; payload registers are not reset.
module bitplane_fetch_sequencer
    import bfs_pkg::*;
#(
    parameter int LINE_CYCLES = 227
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_item,

    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_item,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t       cfg;

    // input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    in_item_t   in_item_reg;
    logic       in_accept;

    // sequencer state and result stage
    seq_state_t state_reg;
    seq_state_t state_next;
    seq_state_t state_sig;
    seq_state_t state_step;
    out_item_t  result;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    logic       advance;
    logic       step;

    assign pready = 1'b1;

    bfs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Result register frees up when empty or being taken this cycle.
    assign advance   = !out_valid_reg || !out_stall;
    // Hold the input only when it has an item that cannot move on.
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    // The state steps exactly once per item, when it enters the result register.
    assign step      = in_valid_reg && advance;

    assign in_valid_next  = in_stall ? in_valid_reg : in_valid;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    bfs_signals u_signals (
        .state_in  (state_reg),
        .item      (in_item_reg),
        .enhanced  (cfg.enhanced_rules),
        .state_out (state_sig)
    );

    bfs_fetch #(
        .LINE_CYCLES (LINE_CYCLES)
    ) u_fetch (
        .state_in  (state_sig),
        .hpos      (in_item_reg.hpos),
        .end_line  (in_item_reg.end_line),
        .cfg       (cfg),
        .state_out (state_step),
        .result    (result)
    );

    assign state_next = step ? state_step : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_item;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Input side can only be held off while a finished result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // End-of-line results carry no fetch or draw information.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.line_end) |->
            (out_item.fetch_plane == 3'd0 && !out_item.draw_odd && !out_item.draw_even))
        else $error("end-of-line result carries fetch or draw flags");

    // Hires fetches only ever name planes one to four.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.fetch_hires) |->
            (out_item.fetch_plane != 3'd0 && out_item.fetch_plane <= HIRES_MAX_PLANES))
        else $error("hires fetch outside planes one to four");

    // An item held in the input register enters the result stage on the next free cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid) |=> out_valid)
        else $error("pending item did not reach the result register");

endmodule

// File: src/bfs_cfg.sv
// APB-style configuration registers of the bitplane fetch sequencer.
// Depends on bfs_pkg (register map, cfg_t).
module bfs_cfg
    import bfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr;

    assign index = reg_index_t'(paddr[3:2]);
    assign wr    = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (index)
                REG_ENHANCED:    cfg_next.enhanced_rules = pwdata[0];
                REG_SCROLL_ODD:  cfg_next.scroll_odd     = pwdata[2:0];
                REG_SCROLL_EVEN: cfg_next.scroll_even    = pwdata[2:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_ENHANCED:    prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.enhanced_rules};
            REG_SCROLL_ODD:  prdata = {{(PDATA_W-3){1'b0}}, cfg_reg.scroll_odd};
            REG_SCROLL_EVEN: prdata = {{(PDATA_W-3){1'b0}}, cfg_reg.scroll_even};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/bfs_signals.sv
// Applies one item's signal flags to the sequencer state (original or enhanced rules).
// Depends on bfs_pkg (in_item_t, seq_state_t). Purely combinational.
module bfs_signals
    import bfs_pkg::*;
(
    input  seq_state_t state_in,
    input  in_item_t   item,
    input  logic       enhanced,
    output seq_state_t state_out
);

    always_comb
    begin
        seq_state_t s;
        logic       shw;
        logic       rhw;
        logic       st;
        logic       sp;
        s   = state_in;
        shw = item.start_hw;
        rhw = item.stop_hw;
        st  = item.fetch_start;
        sp  = item.fetch_stop;

        if (item.con_write)
        begin
            s.control_nibble = item.con_value;
        end

        if (item.enable_clear && !item.enable_set)
        begin
            s.dma_enable   = 1'b0;
            s.running      = 1'b0;
            s.slot_counter = '0;
        end
        else if (item.enable_set && !item.enable_clear)
        begin
            s.dma_enable = 1'b1;
            if (enhanced)
            begin
                s.running = (s.running || s.hw_started) && s.vert_window && s.fetch_started;
            end
        end

        if (item.vert_set && !item.vert_clear)
        begin
            s.vert_window = 1'b1;
            s.shown_flag  = 1'b1;
        end
        else if (item.vert_clear && !item.vert_set)
        begin
            s.vert_window  = 1'b0;
            s.running      = 1'b0;
            s.slot_counter = '0;
        end

        if (enhanced)
        begin
            if (shw && !rhw)
            begin
                s.hw_started = 1'b1;
                s.running    = s.running || (s.fetch_started && !sp);
            end
            else if (rhw && !shw)
            begin
                s.hw_stopped = 1'b1;
            end

            // both hw edges together block the fetch window flags
            if (!(shw && rhw))
            begin
                if (st && sp)
                begin
                    if (shw)
                    begin
                        s.fetch_started = 1'b1;
                        s.running = (s.running || s.hw_started) && s.vert_window
                                    && s.dma_enable;
                    end
                    else if (rhw)
                    begin
                        s.fetch_stopped = s.fetch_stopped || s.running;
                        s.fetch_started = 1'b1;
                    end
                    else
                    begin
                        s.fetch_stopped = s.fetch_stopped || s.running;
                        s.fetch_started = 1'b1;
                        s.running = (s.running || s.hw_started) && s.vert_window
                                    && s.dma_enable;
                    end
                end
                else if (st)
                begin
                    s.fetch_started = 1'b1;
                    s.running = (s.running || s.hw_started) && s.vert_window && s.dma_enable;
                end
                else if (sp)
                begin
                    s.fetch_started = 1'b0;
                    s.fetch_stopped = s.fetch_stopped || s.running;
                end
            end
        end
        else
        begin
            if (shw && !rhw)
            begin
                s.hw_started = 1'b1;
            end
            else if (rhw && !shw)
            begin
                s.hw_stopped = s.hw_stopped || s.running;
            end

            if (st && sp)
            begin
                if (s.running)
                begin
                    s.fetch_started = 1'b0;
                    s.fetch_stopped = 1'b1;
                end
                else
                begin
                    s.fetch_started = s.fetch_started || s.hw_started;
                    s.running = s.hw_started && s.vert_window && s.dma_enable;
                end
            end
            else if (st)
            begin
                s.fetch_started = s.fetch_started || s.hw_started;
                s.running = (s.running || s.hw_started) && s.vert_window && s.dma_enable;
            end
            else if (sp)
            begin
                if (s.running)
                begin
                    s.fetch_started = 1'b0;
                end
                s.fetch_stopped = s.fetch_stopped || s.running;
            end
        end

        state_out = s;
    end

endmodule

// File: src/bfs_fetch.sv
// Fetch slot step: end-of-line handling, unit counter, plane select and draw flags.
// Depends on bfs_pkg (slot tables, slot_plane, state and item types). Combinational.
module bfs_fetch
    import bfs_pkg::*;
#(
    parameter int LINE_CYCLES = 227
)
(
    input  seq_state_t state_in,
    input  logic [7:0] hpos,
    input  logic       end_line,
    input  cfg_t       cfg,
    output seq_state_t state_out,
    output out_item_t  result
);

    localparam logic [8:0] LINE_LIMIT = 9'(LINE_CYCLES);

    always_comb
    begin
        seq_state_t s;
        out_item_t  r;
        logic       hires;
        logic [2:0] plane;
        logic       modulo;
        logic [2:0] mask;
        s      = state_in;
        r      = '0;
        plane  = '0;
        modulo = 1'b0;
        hires  = s.control_nibble[3];
        mask   = hires ? 3'b011 : 3'b111;

        if (end_line)
        begin
            s.hw_stopped = 1'b0;
            if (cfg.enhanced_rules)
            begin
                s.hw_started    = 1'b0;
                s.fetch_stopped = 1'b0;
            end
            r.line_end   = 1'b1;
            r.line_shown = s.shown_flag;
            s.shown_flag = 1'b0;
        end
        else
        begin
            r.line_shown = s.shown_flag;
            if ({1'b0, hpos} < LINE_LIMIT)
            begin
                // unit boundary: close out last unit or arm it
                if ((s.slot_counter == 3'd0) && s.running)
                begin
                    if (s.last_unit)
                    begin
                        s.running       = 1'b0;
                        s.last_unit     = 1'b0;
                        s.fetch_stopped = 1'b0;
                        if (!cfg.enhanced_rules)
                        begin
                            s.hw_started = 1'b0;
                        end
                    end
                    else if (s.hw_stopped || s.fetch_stopped)
                    begin
                        s.last_unit = 1'b1;
                    end
                end

                if (s.running)
                begin
                    plane          = slot_plane(s.control_nibble, s.slot_counter);
                    modulo         = s.last_unit && (!hires || s.slot_counter[2]);
                    s.slot_counter = s.slot_counter + 3'd1;
                end
                else
                begin
                    s.slot_counter = '0;
                end

                r.fetch_plane  = plane;
                r.fetch_hires  = (plane != 3'd0) && hires;
                r.fetch_modulo = (plane != 3'd0) && modulo;
                r.draw_odd     = (hpos[2:0] & mask) == (cfg.scroll_odd & mask);
                r.draw_even    = (hpos[2:0] & mask) == (cfg.scroll_even & mask);
            end
        end

        state_out = s;
        result    = r;
    end

endmodule

// File: tb/tb_bitplane_fetch_sequencer.sv
// Self-checking testbench for the bitplane fetch sequencer: directed and random
// display-cycle items, APB register setup between phases. Needs bfs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bitplane_fetch_sequencer;
    import bfs_pkg::*;

    localparam int LINE_LEN     = 227;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 85;
    localparam int PHASE_COUNT  = 6;

    // slot order of the plane fetches within one 8-slot fetch unit, 0 = free slot
    localparam logic [2:0] LORES_ORDER [8] = '{3'd0, 3'd4, 3'd6, 3'd2, 3'd0, 3'd3, 3'd5, 3'd1};
    localparam logic [2:0] HIRES_ORDER [4] = '{3'd4, 3'd2, 3'd3, 3'd1};

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_item_t           in_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_item;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bitplane_fetch_sequencer #(
        .LINE_CYCLES(LINE_LEN)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the sequencer flags as the block should hold them.
    // ------------------------------------------------------------------
    logic       rules_enh;          // enhanced signal rules selected
    logic [2:0] odd_phase;
    logic [2:0] even_phase;

    logic       win_open;           // vertical window
    logic       dma_on;
    logic       hw_start_seen;
    logic       hw_stop_seen;
    logic       ddf_started;        // programmed fetch window opened
    logic       ddf_stopped;
    logic       fetching;           // fetch state machine running
    logic       in_last_unit;
    logic [3:0] ctrl_nib;           // hires + plane count
    logic [2:0] slot_cnt;
    logic       shown_seen;

    in_item_t   pending_items[$];       // stimulus waiting for the driver
    out_item_t  expected_results[$];    // predicted results, oldest first
    int         items_queued = 0;
    int         errors = 0;
    int         cycles = 0;
    bit         in_took = 1'b0;         // item accepted at the last rising edge
    int         gap_left = 0;
    int         burst_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int         stall_left = 0;

    // Applies one display cycle to the predictor state and returns its result.
    function automatic out_item_t step_sequencer(input in_item_t it);
        out_item_t  r;
        logic       hires;
        logic       modulo;
        logic [2:0] plane;
        logic [2:0] cnt;
        logic [2:0] mask;
        logic       shw, rhw, st, sp;
        r      = '0;
        plane  = 3'd0;
        modulo = 1'b0;
        shw    = it.start_hw;
        rhw    = it.stop_hw;
        st     = it.fetch_start;
        sp     = it.fetch_stop;

        if (it.con_write)
            ctrl_nib = it.con_value;

        // a set and clear of the same flag together cancel out
        if (it.enable_clear && !it.enable_set)
        begin
            dma_on   = 1'b0;
            fetching = 1'b0;
            slot_cnt = 3'd0;
        end
        else if (it.enable_set && !it.enable_clear)
        begin
            dma_on = 1'b1;
            if (rules_enh)
                fetching = (fetching || hw_start_seen) && win_open && ddf_started;
        end

        if (it.vert_set && !it.vert_clear)
        begin
            win_open   = 1'b1;
            shown_seen = 1'b1;
        end
        else if (it.vert_clear && !it.vert_set)
        begin
            win_open = 1'b0;
            fetching = 1'b0;
            slot_cnt = 3'd0;
        end

        if (!rules_enh)
        begin
            if (shw && !rhw)
                hw_start_seen = 1'b1;
            else if (rhw && !shw)
                hw_stop_seen = hw_stop_seen || fetching;

            // fetch start and stop together: stop wins while running
            if (st && sp)
            begin
                if (fetching)
                begin
                    ddf_started = 1'b0;
                    ddf_stopped = 1'b1;
                end
                else
                begin
                    ddf_started = ddf_started || hw_start_seen;
                    fetching    = hw_start_seen && win_open && dma_on;
                end
            end
            else if (st)
            begin
                ddf_started = ddf_started || hw_start_seen;
                fetching    = (fetching || hw_start_seen) && win_open && dma_on;
            end
            else if (sp)
            begin
                if (fetching)
                    ddf_started = 1'b0;
                ddf_stopped = ddf_stopped || fetching;
            end
        end
        else
        begin
            if (shw && !rhw)
            begin
                hw_start_seen = 1'b1;
                fetching      = fetching || (ddf_started && !sp);
            end
            else if (rhw && !shw)
            begin
                hw_stop_seen = 1'b1;
            end

            if (!(shw && rhw))
            begin
                if (st && sp)
                begin
                    if (shw)
                    begin
                        ddf_started = 1'b1;
                        fetching    = (fetching || hw_start_seen) && win_open && dma_on;
                    end
                    else if (rhw)
                    begin
                        ddf_stopped = ddf_stopped || fetching;
                        ddf_started = 1'b1;
                    end
                    else
                    begin
                        ddf_stopped = ddf_stopped || fetching;
                        ddf_started = 1'b1;
                        fetching    = (fetching || hw_start_seen) && win_open && dma_on;
                    end
                end
                else if (st)
                begin
                    ddf_started = 1'b1;
                    fetching    = (fetching || hw_start_seen) && win_open && dma_on;
                end
                else if (sp)
                begin
                    ddf_started = 1'b0;
                    ddf_stopped = ddf_stopped || fetching;
                end
            end
        end

        // end of line: only the end mark and the shown flag come out
        if (it.end_line)
        begin
            hw_stop_seen = 1'b0;
            if (rules_enh)
            begin
                hw_start_seen = 1'b0;
                ddf_stopped   = 1'b0;
            end
            r.line_end   = 1'b1;
            r.line_shown = shown_seen;
            shown_seen   = 1'b0;
            return r;
        end

        r.line_shown = shown_seen;
        if (it.hpos >= LINE_LEN)
            return r;

        // unit boundary: finish after the last unit, or mark the last unit
        if (slot_cnt == 3'd0 && fetching)
        begin
            if (in_last_unit)
            begin
                fetching     = 1'b0;
                in_last_unit = 1'b0;
                ddf_stopped  = 1'b0;
                if (!rules_enh)
                    hw_start_seen = 1'b0;
            end
            else if (hw_stop_seen || ddf_stopped)
            begin
                in_last_unit = 1'b1;
            end
        end

        hires = ctrl_nib[3];
        if (fetching)
        begin
            cnt = ctrl_nib[2:0];
            if (hires)
            begin
                // hires with more than four planes fetches nothing
                plane = (cnt > 3'd4) ? 3'd0 : HIRES_ORDER[slot_cnt[1:0]];
            end
            else
            begin
                // lores with seven planes fetches like four
                if (cnt == 3'd7)
                    cnt = 3'd4;
                plane = LORES_ORDER[slot_cnt];
            end
            if (plane > cnt)
                plane = 3'd0;
            modulo   = in_last_unit && (!hires || slot_cnt >= 3'd4);
            slot_cnt = slot_cnt + 3'd1;
        end
        else
        begin
            slot_cnt = 3'd0;
        end

        mask           = hires ? 3'b011 : 3'b111;
        r.fetch_plane  = plane;
        r.fetch_hires  = (plane != 3'd0) && hires;
        r.fetch_modulo = (plane != 3'd0) && modulo;
        r.draw_odd     = (it.hpos[2:0] & mask) == (odd_phase & mask);
        r.draw_even    = (it.hpos[2:0] & mask) == (even_phase & mask);
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endtask

    task automatic queue_item(input in_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic in_item_t idle_at(input int hpos);
        in_item_t it;
        it      = '0;
        it.hpos = 8'(hpos);
        return it;
    endfunction

    // One scanline in compressed form: hpos climbs one per item, the window
    // signals arrive in a plausible order, and a stray flag shows up now and then.
    task automatic queue_line;
        int       n, base, k;
        int       at_hw_start, at_fetch_start, at_fetch_stop, at_hw_stop;
        in_item_t it;
        n              = $urandom_range(12, 64);
        base           = ($urandom_range(0, 7) == 0) ? $urandom_range(170, 240)
                                                      : $urandom_range(0, 40);
        at_hw_start    = $urandom_range(0, 4);
        at_fetch_start = at_hw_start + $urandom_range(0, 6);
        at_fetch_stop  = at_fetch_start + $urandom_range(0, n / 2);
        at_hw_stop     = $urandom_range(at_fetch_start, n - 1);
        for (k = 0; k < n; k++)
        begin
            it = idle_at(base + k);
            if (k == 0)
            begin
                it.con_write  = ($urandom_range(0, 2) != 0);
                it.con_value  = 4'($urandom);
                it.enable_set = ($urandom_range(0, 2) != 0);
                it.vert_set   = ($urandom_range(0, 4) < 2);
            end
            it.start_hw    = (k == at_hw_start);
            it.fetch_start = (k == at_fetch_start);
            it.fetch_stop  = (k == at_fetch_stop);
            it.stop_hw     = (k == at_hw_stop);
            // stray flag: one of the bits between end_line and con_value
            if ($urandom_range(0, 29) == 0)
                it = it ^ in_item_t'(22'(1) << $urandom_range(1, 8));
            queue_item(it);
        end
        it = idle_at($urandom);
        if ($urandom_range(0, 3) == 0)
            it = in_item_t'($urandom);
        it.end_line = 1'b1;
        queue_item(it);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENHANCED:    rules_enh  = value[0];
            REG_SCROLL_ODD:  odd_phase  = value[2:0];
            REG_SCROLL_EVEN: even_phase = value[2:0];
            default: ;
        endcase
    endtask

    // Block is idle once nothing is queued, offered or owed; the wait then
    // runs on to cover the two-stage pipeline.
    task automatic wait_drained;
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps; valid holds while stalled.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    // roughly one burst in four runs straight into the next
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: switches between no stall, coin-flip stall and a periodic stall.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            stall_left = $urandom_range(32, 200);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            STALL_RANDOM:   out_stall <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: out_stall <= (stall_left % 4 != 0);
            default:        out_stall <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: predict at input accept, check at output accept.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_results.push_back(step_sequencer(in_item));
            in_took = 1'b1;
        end
        else
        begin
            in_took = 1'b0;
        end

        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %p", $time, out_item);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.fetch_plane !== want.fetch_plane)
                    flag_mismatch("fetch_plane", 8'(want.fetch_plane),
                                  8'(out_item.fetch_plane));
                if (out_item.fetch_hires !== want.fetch_hires)
                    flag_mismatch("fetch_hires", 8'(want.fetch_hires),
                                  8'(out_item.fetch_hires));
                if (out_item.fetch_modulo !== want.fetch_modulo)
                    flag_mismatch("fetch_modulo", 8'(want.fetch_modulo),
                                  8'(out_item.fetch_modulo));
                if (out_item.draw_odd !== want.draw_odd)
                    flag_mismatch("draw_odd", 8'(want.draw_odd), 8'(out_item.draw_odd));
                if (out_item.draw_even !== want.draw_even)
                    flag_mismatch("draw_even", 8'(want.draw_even), 8'(out_item.draw_even));
                if (out_item.line_end !== want.line_end)
                    flag_mismatch("line_end", 8'(want.line_end), 8'(out_item.line_end));
                if (out_item.line_shown !== want.line_shown)
                    flag_mismatch("line_shown", 8'(want.line_shown),
                                  8'(out_item.line_shown));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        in_item_t   it;
        int         ph, k, target;
        logic       enh_plan [PHASE_COUNT];
        logic [2:0] odd_plan [PHASE_COUNT];
        logic [2:0] even_plan[PHASE_COUNT];

        enh_plan  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        odd_plan  = '{3'd7, 3'd3, 3'd0, 3'd7, 3'd5, 3'd2};
        even_plan = '{3'd7, 3'd5, 3'd7, 3'd0, 3'd1, 3'd6};

        // predictor starts from the reset state
        rules_enh     = 1'b0;
        odd_phase     = 3'd0;
        even_phase    = 3'd0;
        win_open      = 1'b0;
        dma_on        = 1'b0;
        hw_start_seen = 1'b0;
        hw_stop_seen  = 1'b0;
        ddf_started   = 1'b0;
        ddf_stopped   = 1'b0;
        fetching      = 1'b0;
        in_last_unit  = 1'b0;
        ctrl_nib      = 4'd0;
        slot_cnt      = 3'd0;
        shown_seen    = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed line under reset settings (original rules, zero scroll).
        queue_item(idle_at(LINE_LEN - 1));      // last cycle inside the line
        it = '1;                                // every flag at once, end mark too
        queue_item(it);
        it.end_line = 1'b0;                     // every pair together, cycle outside line
        queue_item(it);
        queue_item(idle_at(LINE_LEN));          // first cycle outside the line
        it = idle_at(10);                       // seven lores planes fetch as four
        it.con_write  = 1'b1;
        it.con_value  = 4'h7;
        it.enable_set = 1'b1;
        it.vert_set   = 1'b1;
        it.start_hw   = 1'b1;
        queue_item(it);
        it = idle_at(11);
        it.fetch_start = 1'b1;
        queue_item(it);
        for (k = 12; k < 18; k++)
            queue_item(idle_at(k));
        it = idle_at(20);                       // hires with five planes: no fetch
        it.con_write = 1'b1;
        it.con_value = 4'hD;
        queue_item(it);
        queue_item(idle_at(21));
        it = idle_at(23);                       // hires four planes, then stop
        it.con_write  = 1'b1;
        it.con_value  = 4'hC;
        it.fetch_stop = 1'b1;
        queue_item(it);
        for (k = 24; k < 32; k++)
            queue_item(idle_at(k));
        it = idle_at(0);
        it.end_line = 1'b1;
        queue_item(it);
        wait_drained();

        // Random phases, each under its own register settings.
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_reg(REG_ENHANCED,    PDATA_W'(enh_plan[ph]));
            write_reg(REG_SCROLL_ODD,  PDATA_W'(odd_plan[ph]));
            write_reg(REG_SCROLL_EVEN, PDATA_W'(even_plan[ph]));
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // short run of fully random items
                    repeat ($urandom_range(1, 4))
                        queue_item(in_item_t'($urandom));
                end
                else
                begin
                    queue_line();
                end
            end
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: bitplane_fetch_sequencer.f
src/bfs_pkg.sv
src/bfs_cfg.sv
src/bfs_signals.sv
src/bfs_fetch.sv
src/bitplane_fetch_sequencer.sv
tb/tb_bitplane_fetch_sequencer.sv
